// ===== rtl/ray_octant_binning_unit_macros.svh =====
// assertion helpers
`ifndef RAY_OCTANT_BINNING_UNIT_MACROS_SVH
`define RAY_OCTANT_BINNING_UNIT_MACROS_SVH
`define ROB_ASSERT_IMPL(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ROB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/rob_pkg.sv =====
`default_nettype none
package rob_pkg;
  localparam int unsigned SLOT_MAX = 64;
  localparam int unsigned DEF_BUCKET_DEPTH = 64;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic op;
    logic [31:0] ray_id;
    logic [31:0] tnear;
    logic [31:0] tfar;
    logic [31:0] geom_id;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
  } rob_in_t;

  typedef struct packed {
    logic [2:0] octant;
    logic [31:0] out_ray_id;
    logic last;
    logic nothing_left;
  } rob_out_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DRAIN, ST_TAIL} rob_state_t;

  function automatic logic f_neg(input logic [31:0] v);
    return v[31] && (v[30:0] != 31'd0) && !((v[30:23] == 8'hff) && (v[22:0] != 23'd0));
  endfunction

  function automatic logic f_nan(input logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
  endfunction

  // ieee a > b
  function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (f_nan(a) || f_nan(b)) r = 1'b0;
    else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) r = 1'b0;
    else if (!a[31] && !b[31]) r = a[30:0] > b[30:0];
    else if (a[31] && b[31]) r = a[30:0] < b[30:0];
    else r = !a[31];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/rob_store.sv =====
`default_nettype none
module rob_store import rob_pkg::*; (
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [8:0]  waddr,
  input  wire logic [31:0] wdata,
  input  wire logic [8:0]  raddr,
  output logic [31:0]      rdata
);
  logic [31:0] mem [0:8*SLOT_MAX-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ray_octant_binning_unit.sv =====
`default_nettype none
// ray octant binning unit
// request channel: start/busy with in_req; taken when start is high and busy is low.
// insert requests that survive the tnear/tfar and geom_id checks append their id to
// one of eight buckets picked by the direction sign bits. a flush request drains the
// lowest non-empty bucket, or gives one result with nothing_left set.
// results: out_valid strobes one cycle per result with out_res; the receiver
// cannot stall, so results are produced at one per cycle.
// an insert that does not fill a bucket leaves busy low; one that fills it drains that
// bucket like a flush. a drain of n ids reads the bucket memory one entry per cycle
// through its single read port; each id passes the registered read and the result
// register, and the last result appears in the same cycle that busy drops.
// an empty flush gives its result in the cycle after the request.
// reset (rst_n low, synchronous) clears all bucket counts; the id memory is not
// cleared since only written entries are read.
`include "ray_octant_binning_unit_macros.svh"
module ray_octant_binning_unit import rob_pkg::*; #(
  parameter int unsigned BUCKET_DEPTH = DEF_BUCKET_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire rob_in_t in_req,
  output logic         busy,
  output logic         out_valid,
  output rob_out_t     out_res
);
  logic [6:0] cnt_r [0:7];
  logic [6:0] cnt_nxt [0:7];
  rob_state_t st_r, st_nxt;
  logic [2:0] oct_r, oct_nxt;
  logic [6:0] n_r, n_nxt;
  logic [5:0] k_r, k_nxt;
  logic ov_r, ov_nxt;
  rob_out_t res_r, res_nxt;
  logic we;
  logic [8:0] waddr, raddr;
  logic [31:0] rdata;
  logic acc;
  logic [2:0] oct;
  logic [6:0] c;
  logic found;
  logic [2:0] first;

  rob_store u_store (.clk, .we, .waddr, .wdata(in_req.ray_id), .raddr, .rdata);

  assign acc = start && !busy;
  assign busy = (st_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_res = res_r;
  assign oct = {f_neg(in_req.dir_z), f_neg(in_req.dir_y), f_neg(in_req.dir_x)};
  assign c = (cnt_r[oct] >= 7'(SLOT_MAX)) ? 7'(SLOT_MAX - 1) : cnt_r[oct];

  always_comb begin
    found = 1'b0;
    first = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cnt_r[i] != 7'd0) begin
        found = 1'b1;
        first = 3'(i);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    oct_nxt = oct_r;
    n_nxt = n_r;
    k_nxt = k_r;
    ov_nxt = 1'b0;
    res_nxt = res_r;
    for (int i = 0; i < 8; i++) cnt_nxt[i] = cnt_r[i];
    we = 1'b0;
    waddr = {oct, c[5:0]};
    raddr = {oct_r, k_r};
    case (st_r)
      ST_IDLE: begin
        if (acc && in_req.op == OP_FLUSH) begin
          if (found) begin
            oct_nxt = first;
            n_nxt = cnt_r[first];
            k_nxt = 6'd0;
            cnt_nxt[first] = 7'd0;
            st_nxt = ST_DRAIN;
          end else begin
            ov_nxt = 1'b1;
            res_nxt = '{octant: 3'd0, out_ray_id: 32'd0, last: 1'b0, nothing_left: 1'b1};
          end
        end else if (acc && !f_gt(in_req.tnear, in_req.tfar) && in_req.geom_id != 32'd0) begin
          we = 1'b1;
          if (c + 7'd1 >= 7'(BUCKET_DEPTH)) begin
            cnt_nxt[oct] = 7'd0;
            oct_nxt = oct;
            n_nxt = c + 7'd1;
            k_nxt = 6'd0;
            st_nxt = ST_DRAIN;
          end else begin
            cnt_nxt[oct] = c + 7'd1;
          end
        end
      end
      ST_DRAIN: begin
        // read issued for k_r, data next cycle
        k_nxt = k_r + 6'd1;
        if ({1'b0, k_r} + 7'd1 >= n_r) st_nxt = ST_TAIL;
        ov_nxt = (k_r != 6'd0);
        res_nxt = '{octant: oct_r, out_ray_id: rdata, last: 1'b0, nothing_left: 1'b0};
      end
      ST_TAIL: begin
        ov_nxt = 1'b1;
        res_nxt = '{octant: oct_r, out_ray_id: rdata, last: 1'b1, nothing_left: 1'b0};
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      for (int i = 0; i < 8; i++) cnt_r[i] <= 7'd0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      for (int i = 0; i < 8; i++) cnt_r[i] <= cnt_nxt[i];
    end
    oct_r <= oct_nxt;
    n_r <= n_nxt;
    k_r <= k_nxt;
    res_r <= res_nxt;
  end

  `ROB_ASSERT_IMPL(a_cnt_below_depth, cnt_r[oct] < 7'(BUCKET_DEPTH), "bucket count over depth")
  `ROB_ASSERT_NEXT(a_tail_last, st_r == ST_TAIL, out_valid && out_res.last, "missing last")
  `ROB_ASSERT_IMPL(a_nl_clean, !(out_valid && out_res.nothing_left && out_res.last),
    "nothing_left with last")
  `ROB_ASSERT_NEXT(a_drain_holds, st_r == ST_DRAIN, busy, "drain dropped busy")
endmodule
`default_nettype wire

// ===== sim/tb_ray_octant_binning_unit.sv =====
`default_nettype none
module tb_ray_octant_binning_unit;
  import rob_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = DEF_BUCKET_DEPTH;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam logic [31:0] F_POS_ONE = 32'h3f80_0000;
  localparam logic [31:0] F_NEG_ONE = 32'hbf80_0000;
  localparam logic [31:0] F_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_QNAN = 32'h7fc0_0000;
  localparam logic [31:0] F_NEG_NAN = 32'hffc0_0001;
  localparam logic [31:0] F_POS_INF = 32'h7f80_0000;
  localparam logic [31:0] F_NEG_INF = 32'hff80_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  rob_in_t in_req = '0;
  logic busy;
  logic out_valid;
  rob_out_t out_res;

  ray_octant_binning_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_req(in_req),
    .busy(busy), .out_valid(out_valid), .out_res(out_res)
  );

  always #5 clk = ~clk;

  logic [31:0] bin_ids [8][SLOT_MAX];
  int unsigned bin_fill [8];
  rob_out_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned bins_drained = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;
  bit quiet = 1'b0;

  typedef struct {
    rob_in_t req;
    bit has_fixed;
    rob_out_t fixed;
  } directed_row_t;

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic is_negative(input logic [31:0] v);
    return !is_nan(v) && v[31] && (v[30:0] != 31'd0);
  endfunction

  function automatic logic float_greater(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    if (a[31] != b[31]) return !a[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  task automatic drain_bin(input int unsigned oct);
    rob_out_t r;
    for (int unsigned k = 0; k < bin_fill[oct]; k++) begin
      r.octant = oct[2:0];
      r.out_ray_id = bin_ids[oct][k];
      r.last = (k + 1 == bin_fill[oct]);
      r.nothing_left = 1'b0;
      pending_results.push_back(r);
    end
    bin_fill[oct] = 0;
    bins_drained++;
  endtask

  task automatic predict_binning(input rob_in_t req);
    int unsigned oct;
    rob_out_t r;
    if (req.op == OP_FLUSH) begin
      for (int unsigned i = 0; i < 8; i++) begin
        if (bin_fill[i] != 0) begin
          drain_bin(i);
          return;
        end
      end
      r = '0;
      r.nothing_left = 1'b1;
      pending_results.push_back(r);
      return;
    end
    if (float_greater(req.tnear, req.tfar) || req.geom_id == 32'd0) return;
    oct = {is_negative(req.dir_z), is_negative(req.dir_y), is_negative(req.dir_x)};
    bin_ids[oct][bin_fill[oct]] = req.ray_id;
    bin_fill[oct]++;
    if (bin_fill[oct] >= DEPTH) drain_bin(oct);
  endtask

  always @(posedge clk) begin
    rob_out_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: octant %0d id %h last %b none %b",
                   out_res.octant, out_res.out_ray_id, out_res.last, out_res.nothing_left);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_res !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp oct %0d id %h last %b none %b, %s",
                     exp_r.octant, exp_r.out_ray_id, exp_r.last, exp_r.nothing_left,
                     $sformatf("got oct %0d id %h last %b none %b",
                               out_res.octant, out_res.out_ray_id, out_res.last,
                               out_res.nothing_left));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_request(input rob_in_t req);
    while (!quiet && $urandom_range(99) < 16) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    predict_binning(req);
    requests_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_dir();
    case ($urandom_range(7))
      0: return F_NEG_ZERO;
      1: return F_POS_ZERO;
      2: return $urandom_range(1) ? F_QNAN : F_NEG_NAN;
      3: return $urandom_range(1) ? F_POS_INF : F_NEG_INF;
      default: return $urandom();
    endcase
  endfunction

  function automatic rob_in_t random_ray(input bit well_formed);
    rob_in_t q;
    q.op = OP_INSERT;
    q.ray_id = $urandom();
    q.dir_x = random_dir();
    q.dir_y = random_dir();
    q.dir_z = random_dir();
    if (well_formed) begin
      q.tnear = {1'b0, 31'($urandom_range(32'h3f00_0000))};
      q.tfar = {1'b0, 8'h7f, 23'($urandom())} | 32'h4000_0000;
      q.geom_id = $urandom() | 32'd1;
    end else begin
      q.tnear = $urandom();
      q.tfar = $urandom();
      q.geom_id = $urandom_range(3) == 0 ? 32'd0 : $urandom();
    end
    return q;
  endfunction

  function automatic rob_in_t make_ray(input logic [31:0] id, input logic [31:0] tn,
                                       input logic [31:0] tf, input logic [31:0] g,
                                       input logic [31:0] dx, input logic [31:0] dy,
                                       input logic [31:0] dz);
    rob_in_t q;
    q.op = OP_INSERT; q.ray_id = id; q.tnear = tn; q.tfar = tf;
    q.geom_id = g; q.dir_x = dx; q.dir_y = dy; q.dir_z = dz;
    return q;
  endfunction

  function automatic rob_out_t fixed_result(input logic [2:0] o, input logic [31:0] id,
                                            input logic l, input logic n);
    rob_out_t r;
    r.octant = o; r.out_ray_id = id; r.last = l; r.nothing_left = n;
    return r;
  endfunction

  directed_row_t directed_rows [$];

  initial begin
    rob_in_t q;
    rob_in_t flush_req;
    directed_row_t row;
    flush_req = '0;
    flush_req.op = OP_FLUSH;
    foreach (bin_fill[i]) bin_fill[i] = 0;

    row.has_fixed = 1'b1;
    row.req = flush_req;
    row.fixed = fixed_result(3'd0, 32'd0, 1'b0, 1'b1);
    directed_rows.push_back(row);
    row.has_fixed = 1'b0;
    row.req = make_ray(32'h1, F_POS_ONE, F_POS_ZERO, 32'h1, F_POS_ONE, F_POS_ONE, F_POS_ONE);
    directed_rows.push_back(row);
    row.req = make_ray(32'h2, F_POS_ZERO, F_POS_ONE, 32'h0, F_NEG_ONE, F_POS_ONE, F_POS_ONE);
    directed_rows.push_back(row);
    row.req = make_ray(32'hffff_ffff, F_QNAN, F_NEG_INF, 32'hffff_ffff,
                       F_NEG_ONE, F_NEG_ONE, F_NEG_ONE);
    directed_rows.push_back(row);
    row.has_fixed = 1'b1;
    row.req = flush_req;
    row.fixed = fixed_result(3'd7, 32'hffff_ffff, 1'b1, 1'b0);
    directed_rows.push_back(row);
    row.has_fixed = 1'b0;
    row.req = make_ray(32'h0, F_NEG_ZERO, F_POS_ZERO, 32'h8000_0000,
                       F_NEG_ZERO, F_NEG_NAN, F_NEG_INF);
    directed_rows.push_back(row);
    row.req = make_ray(32'hdead_beef, F_NEG_INF, F_POS_INF, 32'h1,
                       F_NEG_INF, F_POS_ZERO, F_QNAN);
    directed_rows.push_back(row);
    row.req = make_ray(32'h5555_aaaa, F_NEG_ONE, F_NEG_ONE, 32'h2,
                       F_POS_INF, 32'h8000_0001, 32'hff7f_ffff);
    directed_rows.push_back(row);
    row.req = make_ray(32'haaaa_5555, 32'h7f7f_ffff, F_QNAN, 32'h4,
                       32'h0000_0001, 32'h7fff_ffff, 32'h807f_ffff);
    directed_rows.push_back(row);
    for (int i = 0; i < 4; i++) begin
      row.req = flush_req;
      directed_rows.push_back(row);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_fixed) begin
        send_request(directed_rows[i].req);
        if (pending_results.size() == 0 || pending_results[$] !== directed_rows[i].fixed) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d: prediction off table", i);
        end
      end else send_request(directed_rows[i].req);
    end

    // fill one bin to depth, then mixed traffic
    for (int unsigned k = 0; k < DEPTH; k++) begin
      q = make_ray($urandom(), F_POS_ZERO, F_POS_ONE, 32'h7, F_NEG_ONE, F_POS_ONE, F_NEG_ONE);
      send_request(q);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 100 && n < 160);
      if ($urandom_range(99) < 4) send_request(flush_req);
      else send_request(random_ray($urandom_range(99) < 85));
    end
    quiet = 1'b0;
    for (int i = 0; i < 9; i++) send_request(flush_req);
    start <= 1'b0;

    while (pending_results.size() != 0 && !timed_out) @(posedge clk);
    repeat (4) @(posedge clk);
  end

  initial begin
    wait (rst_n);
    while (1) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
      end
      if (requests_sent > 0 && pending_results.size() == 0 && !start && !busy &&
          requests_sent >= directed_rows.size() + DEPTH + RANDOM_ITEMS + 9) begin
        repeat (4) @(posedge clk);
        $display("sent %0d requests, checked %0d results over %0d bin drains",
                 requests_sent, results_seen, bins_drained);
        if (mismatches == 0 && pending_results.size() == 0) begin
          $display("Regression PASS");
        end else begin
          $display("%0d mismatches", mismatches);
          $display("Regression FAIL");
        end
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
